// File: rtl/mfs_pkg.sv
// Shared constants, command codes and the result record of the music fade sequencer.
package mfs_pkg;

   // default parameter values
   localparam int LEVEL_FRAC_BITS_DEF = 8;
   localparam int TIME_BITS_DEF       = 16;

   // fixed port field widths
   localparam int CMD_W   = 2;
   localparam int TRACK_W = 16;
   localparam int TGT_W   = 15;
   localparam int TICK_W  = 16;
   localparam int GAIN_W  = 7;
   localparam int VOL_W   = 10;
   localparam int GP_W    = 14;  // master * music gain product, at most 10000

   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_PLAY  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUEUE = 2'd2;
   localparam logic [CMD_W-1:0] CMD_FADE  = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MUSIC  = 1'b1;

   localparam logic [GAIN_W-1:0] GAIN_MAX = 7'd100;
   localparam logic [VOL_W-1:0]  VOL_MAX  = 10'd1000;
   localparam int                VOL_DIV  = 1000;
   localparam int                VOL_HALF = 500;

   // divide by 1000 as multiply by ceil(2^30 / 1000), exact for operands below 2^20;
   // the rounded product with fraction bits dropped is at most 1000500
   localparam int                      VOL_Y_W      = 20;
   localparam int                      VOL_RECIP_W  = 21;
   localparam int                      VOL_RECIP_SH = 30;
   localparam logic [VOL_RECIP_W-1:0]  VOL_RECIP    = 21'd1073742;

   typedef struct packed {
      logic [VOL_W-1:0]   volume_level;
      logic [TRACK_W-1:0] playing_track;
      logic               track_present;
      logic               track_start;
      logic               fade_busy;
   } rsp_type;

endpackage

// File: rtl/music_fade_sequencer_core.sv
// Music fade sequencer top level: stream ports, gain registers, result register.
// Every command passes the gain and volume states from input transfer to rsp_tvalid; a
// tick inside a ramp first runs the ramp multiply and the serial divider.
// Flow: one item at a time; the serial ramp divider, one quotient bit per cycle over
// LEVEL_FRAC_BITS+7 bits, is the longest step; req_tready rises with rsp_tvalid once a result
// enters a free result register. A waiting result does not block input, only the next result.
// Reset (synchronous): no track, level 0, no fade, both gains at 100 percent.
module music_fade_sequencer_core #(
   parameter int LEVEL_FRAC_BITS = mfs_pkg::LEVEL_FRAC_BITS_DEF,
   parameter int TIME_BITS       = mfs_pkg::TIME_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // request stream
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // tdata: track_id[15:0], target_level[30:16], fade_out_ticks[46:31],
   //        fade_in_ticks[62:47], delta_ticks[78:63], zero pad [79]
   input  logic [mfs_pkg::REQ_DATA_W-1:0]   req_tdata,
   // tuser: command[1:0]
   input  logic [mfs_pkg::CMD_W-1:0]        req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // tdata: volume_level[9:0], playing_track[25:10], track_present[26],
   //        track_start[27], fade_busy[28], zero pad [31:29]
   output logic [mfs_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // configuration writes
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mfs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [mfs_pkg::GAIN_W-1:0]       csr_data
);

   logic [mfs_pkg::GAIN_W-1:0] master_ff, master_in;
   logic [mfs_pkg::GAIN_W-1:0] music_ff, music_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mfs_pkg::rsp_type           rsp_ff, rsp_in;

   logic             seq_idle;
   logic             req_take;
   logic             res_valid;
   logic             res_take;
   mfs_pkg::rsp_type res;

   assign req_tready = seq_idle;
   assign req_take   = req_tvalid && seq_idle;
   assign csr_ready  = 1'b1;

   // result register frees as soon as it is drained or being drained
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   mfs_seq #(
      .LEVEL_FRAC_BITS(LEVEL_FRAC_BITS),
      .TIME_BITS      (TIME_BITS)
   ) u_seq (
      .clock            (clock),
      .reset            (reset),
      .idle             (seq_idle),
      .req_take         (req_take),
      .in_command       (req_tuser),
      .in_track_id      (req_tdata[15:0]),
      .in_target_level  (req_tdata[30:16]),
      .in_fade_out_ticks(req_tdata[46:31]),
      .in_fade_in_ticks (req_tdata[62:47]),
      .in_delta_ticks   (req_tdata[78:63]),
      .master_gain      (master_ff),
      .music_gain       (music_ff),
      .res_valid        (res_valid),
      .res_take         (res_take),
      .res              (res)
   );

   always_comb begin
      master_in = master_ff;
      music_in  = music_ff;
      if (csr_valid) begin
         unique case (csr_index)
            mfs_pkg::CSR_MASTER: master_in = csr_data;
            mfs_pkg::CSR_MUSIC:  music_in  = csr_data;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff    <= mfs_pkg::GAIN_MAX;
         music_ff     <= mfs_pkg::GAIN_MAX;
         rsp_valid_ff <= 1'b0;
      end else begin
         master_ff    <= master_in;
         music_ff     <= music_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.fade_busy, rsp_ff.track_start, rsp_ff.track_present,
                        rsp_ff.playing_track, rsp_ff.volume_level};

endmodule

// File: rtl/mfs_div.sv
// Serial restoring divider, one quotient bit per cycle; quotient known to fit QW bits.
module mfs_div #(
   parameter int QW  = 15,
   parameter int DVW = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [QW+DVW-1:0] dividend,
   input  logic [DVW-1:0]    divisor,
   output logic              done,
   output logic [QW-1:0]     quotient
);

   localparam int CNTW = $clog2(QW + 1);

   logic            run_ff, run_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [DVW-1:0]  rem_ff, rem_in;
   logic [DVW-1:0]  dvs_ff, dvs_in;
   logic [QW-1:0]   lo_ff, lo_in;
   logic [QW-1:0]   quo_ff, quo_in;

   logic [DVW:0] trial;
   logic [DVW:0] trial_sub;
   logic         fits;

   assign trial     = {rem_ff, lo_ff[QW-1]};
   assign trial_sub = trial - {1'b0, dvs_ff};
   assign fits      = trial >= {1'b0, dvs_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      lo_in   = lo_ff;
      quo_in  = quo_ff;
      if (start) begin
         // the upper part is already below the divisor
         rem_in = dividend[QW+DVW-1:QW];
         lo_in  = dividend[QW-1:0];
         dvs_in = divisor;
         quo_in = '0;
         cnt_in = CNTW'(QW);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? trial_sub[DVW-1:0] : trial[DVW-1:0];
         lo_in  = lo_ff << 1;
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff - CNTW'(1);
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      lo_ff  <= lo_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

`ifndef ASSERT_OFF
   a_rem_below_dvs: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (rem_ff < dvs_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule

// File: rtl/mfs_seq.sv
// Command sequencer: track and ramp state, shared multiplier, divider control.
module mfs_seq #(
   parameter int LEVEL_FRAC_BITS = mfs_pkg::LEVEL_FRAC_BITS_DEF,
   parameter int TIME_BITS       = mfs_pkg::TIME_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   output logic                        idle,
   input  logic                        req_take,
   input  logic [mfs_pkg::CMD_W-1:0]   in_command,
   input  logic [mfs_pkg::TRACK_W-1:0] in_track_id,
   input  logic [mfs_pkg::TGT_W-1:0]   in_target_level,
   input  logic [mfs_pkg::TICK_W-1:0]  in_fade_out_ticks,
   input  logic [mfs_pkg::TICK_W-1:0]  in_fade_in_ticks,
   input  logic [mfs_pkg::TICK_W-1:0]  in_delta_ticks,
   input  logic [mfs_pkg::GAIN_W-1:0]  master_gain,
   input  logic [mfs_pkg::GAIN_W-1:0]  music_gain,
   output logic                        res_valid,
   input  logic                        res_take,
   output mfs_pkg::rsp_type            res
);

   localparam int LW  = LEVEL_FRAC_BITS + 7;
   localparam int BW  = (TIME_BITS > mfs_pkg::GP_W) ? TIME_BITS : mfs_pkg::GP_W;
   localparam int PW  = LW + BW;
   localparam int PW1 = PW + 1;
   localparam int CW  = (LW > mfs_pkg::TGT_W) ? LW : mfs_pkg::TGT_W;
   localparam int TW  = (TIME_BITS > mfs_pkg::TICK_W) ? TIME_BITS : mfs_pkg::TICK_W;
   localparam int TW1 = TW + 1;
   localparam int YW  = mfs_pkg::VOL_Y_W;
   localparam int MW  = mfs_pkg::VOL_Y_W + mfs_pkg::VOL_RECIP_W;
   localparam int QVW = mfs_pkg::VOL_W + 1;

   localparam logic [CW-1:0]  LVL_LIM = CW'(100) << LEVEL_FRAC_BITS;
   localparam logic [LW-1:0]  LVL_MAX = LW'(100) << LEVEL_FRAC_BITS;
   localparam logic [TW-1:0]  T_MAX   = TW'({TIME_BITS{1'b1}});
   localparam logic [PW1-1:0] RND     = PW1'(mfs_pkg::VOL_HALF) << LEVEL_FRAC_BITS;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_EXEC = 4'd1;
   localparam logic [3:0] S_RMUL = 4'd2;
   localparam logic [3:0] S_RDGO = 4'd3;
   localparam logic [3:0] S_RDWT = 4'd4;
   localparam logic [3:0] S_GMUL = 4'd5;
   localparam logic [3:0] S_VMUL = 4'd6;
   localparam logic [3:0] S_VRND = 4'd7;
   localparam logic [3:0] S_VREC = 4'd8;
   localparam logic [3:0] S_DONE = 4'd9;

   function automatic logic [TIME_BITS-1:0] clamp_time(input logic [mfs_pkg::TICK_W-1:0] v);
      logic [TW-1:0] x;
      x = TW'(v);
      if (x == '0) begin
         x = TW'(1);
      end else if (x > T_MAX) begin
         x = T_MAX;
      end
      return x[TIME_BITS-1:0];
   endfunction

   logic [3:0]                  state_ff, state_in;
   logic [LW-1:0]               level_ff, level_in;
   logic [LW-1:0]               start_ff, start_in;
   logic [LW-1:0]               target_ff, target_in;
   logic [TIME_BITS-1:0]        len_ff, len_in;
   logic [TIME_BITS-1:0]        elap_ff, elap_in;
   logic [mfs_pkg::TRACK_W-1:0] cur_ff, cur_in;
   logic                        cur_v_ff, cur_v_in;
   logic [mfs_pkg::TRACK_W-1:0] pend_ff, pend_in;
   logic                        pend_v_ff, pend_v_in;
   logic [LW-1:0]               pend_lvl_ff, pend_lvl_in;
   logic [mfs_pkg::TICK_W-1:0]  pend_fin_ff, pend_fin_in;
   logic                        sw_ff, sw_in;
   logic                        started_ff, started_in;
   logic [mfs_pkg::VOL_W-1:0]   vol_ff, vol_in;

   // captured command and working registers
   logic [mfs_pkg::CMD_W-1:0]   cmd_ff, cmd_in;
   logic [mfs_pkg::TRACK_W-1:0] id_ff, id_in;
   logic [LW-1:0]               tgt_ff, tgt_in;
   logic [mfs_pkg::TICK_W-1:0]  fout_ff, fout_in;
   logic [mfs_pkg::TICK_W-1:0]  fin_ff, fin_in;
   logic [mfs_pkg::TICK_W-1:0]  dt_ff, dt_in;
   logic [LW-1:0]               diff_ff, diff_in;
   logic [PW-1:0]               prod_ff, prod_in;

   logic [CW-1:0]          tgt_ext;
   logic [CW-1:0]          tgt_clamped;
   logic [TW1-1:0]         esum;
   logic [TIME_BITS-1:0]   e_new;
   logic [mfs_pkg::GAIN_W-1:0] mg;
   logic [mfs_pkg::GAIN_W-1:0] gg;
   logic [LW-1:0]          mul_a;
   logic [BW-1:0]          mul_b;
   logic [PW1-1:0]         ysum;
   logic [PW-1:0]          yval;
   logic [MW-1:0]          vrec;
   logic [QVW-1:0]         vq;
   logic                   ramp_up;

   logic                   div_start;
   logic [PW-1:0]          div_dividend;
   logic [BW-1:0]          div_divisor;
   logic                   div_done;
   logic [LW-1:0]          div_q;

   assign tgt_ext     = CW'(in_target_level);
   assign tgt_clamped = (tgt_ext > LVL_LIM) ? LVL_LIM : tgt_ext;

   assign esum  = TW1'(elap_ff) + TW1'(dt_ff);
   assign e_new = (esum > TW1'(T_MAX)) ? {TIME_BITS{1'b1}} : esum[TIME_BITS-1:0];

   assign mg = (master_gain > mfs_pkg::GAIN_MAX) ? mfs_pkg::GAIN_MAX : master_gain;
   assign gg = (music_gain > mfs_pkg::GAIN_MAX) ? mfs_pkg::GAIN_MAX : music_gain;

   assign ramp_up = target_ff >= start_ff;

   // rounding half of the constant divisor, then drop the fraction bits
   assign ysum = {1'b0, prod_ff} + RND;
   assign yval = PW'(ysum >> LEVEL_FRAC_BITS);

   // divide by 1000 through the reciprocal
   assign vrec = MW'(prod_ff[YW-1:0]) * MW'(mfs_pkg::VOL_RECIP);
   assign vq   = vrec[mfs_pkg::VOL_RECIP_SH +: QVW];

   always_comb begin
      case (state_ff)
         S_RMUL: begin
            mul_a = diff_ff;
            mul_b = BW'(elap_ff);
         end
         S_GMUL: begin
            mul_a = LW'(mg);
            mul_b = BW'(gg);
         end
         default: begin
            mul_a = level_ff;
            mul_b = BW'(prod_ff[mfs_pkg::GP_W-1:0]);
         end
      endcase
   end

   assign div_start    = (state_ff == S_RDGO);
   assign div_dividend = prod_ff;
   assign div_divisor  = BW'(len_ff);

   mfs_div #(
      .QW (LW),
      .DVW(BW)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .done    (div_done),
      .quotient(div_q)
   );

   always_comb begin
      state_in    = state_ff;
      level_in    = level_ff;
      start_in    = start_ff;
      target_in   = target_ff;
      len_in      = len_ff;
      elap_in     = elap_ff;
      cur_in      = cur_ff;
      cur_v_in    = cur_v_ff;
      pend_in     = pend_ff;
      pend_v_in   = pend_v_ff;
      pend_lvl_in = pend_lvl_ff;
      pend_fin_in = pend_fin_ff;
      sw_in       = sw_ff;
      started_in  = started_ff;
      vol_in      = vol_ff;
      cmd_in      = cmd_ff;
      id_in       = id_ff;
      tgt_in      = tgt_ff;
      fout_in     = fout_ff;
      fin_in      = fin_ff;
      dt_in       = dt_ff;
      diff_in     = diff_ff;
      prod_in     = prod_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               cmd_in     = in_command;
               id_in      = in_track_id;
               tgt_in     = tgt_clamped[LW-1:0];
               fout_in    = in_fade_out_ticks;
               fin_in     = in_fade_in_ticks;
               dt_in      = in_delta_ticks;
               started_in = 1'b0;
               state_in   = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = S_GMUL;
            unique case (cmd_ff)
               mfs_pkg::CMD_TICK: begin
                  if (len_ff != '0) begin
                     if (e_new < len_ff) begin
                        elap_in  = e_new;
                        diff_in  = ramp_up ? (target_ff - start_ff) : (start_ff - target_ff);
                        state_in = S_RMUL;
                     end else begin
                        level_in = target_ff;
                        start_in = target_ff;
                        len_in   = '0;
                        elap_in  = '0;
                        // fade-out finished: bring in the queued track
                        if (sw_ff && (target_ff == '0) && pend_v_ff) begin
                           cur_in     = pend_ff;
                           cur_v_in   = 1'b1;
                           pend_v_in  = 1'b0;
                           sw_in      = 1'b0;
                           level_in   = '0;
                           start_in   = '0;
                           target_in  = pend_lvl_ff;
                           len_in     = clamp_time(pend_fin_ff);
                           started_in = 1'b1;
                        end
                     end
                  end
               end
               mfs_pkg::CMD_PLAY: begin
                  cur_in     = id_ff;
                  cur_v_in   = 1'b1;
                  pend_v_in  = 1'b0;
                  sw_in      = 1'b0;
                  elap_in    = '0;
                  len_in     = '0;
                  level_in   = tgt_ff;
                  start_in   = tgt_ff;
                  target_in  = tgt_ff;
                  started_in = 1'b1;
               end
               mfs_pkg::CMD_QUEUE: begin
                  elap_in = '0;
                  if (!cur_v_ff) begin
                     cur_in     = id_ff;
                     cur_v_in   = 1'b1;
                     pend_v_in  = 1'b0;
                     sw_in      = 1'b0;
                     level_in   = '0;
                     start_in   = '0;
                     target_in  = tgt_ff;
                     len_in     = clamp_time(fin_ff);
                     started_in = 1'b1;
                  end else if (cur_ff == id_ff) begin
                     start_in  = level_ff;
                     target_in = tgt_ff;
                     len_in    = clamp_time(fin_ff);
                  end else begin
                     pend_in     = id_ff;
                     pend_v_in   = 1'b1;
                     pend_lvl_in = tgt_ff;
                     pend_fin_in = fin_ff;
                     sw_in       = 1'b1;
                     start_in    = level_ff;
                     target_in   = '0;
                     len_in      = clamp_time(fout_ff);
                  end
               end
               mfs_pkg::CMD_FADE: begin
                  start_in  = level_ff;
                  target_in = tgt_ff;
                  len_in    = clamp_time(fin_ff);
                  elap_in   = '0;
               end
            endcase
         end
         S_RMUL: begin
            prod_in  = PW'(mul_a) * PW'(mul_b);
            state_in = S_RDGO;
         end
         S_RDGO: begin
            state_in = S_RDWT;
         end
         S_RDWT: begin
            if (div_done) begin
               level_in = ramp_up ? (start_ff + div_q) : (start_ff - div_q);
               state_in = S_GMUL;
            end
         end
         S_GMUL: begin
            prod_in  = PW'(mul_a) * PW'(mul_b);
            state_in = S_VMUL;
         end
         S_VMUL: begin
            prod_in  = PW'(mul_a) * PW'(mul_b);
            state_in = S_VRND;
         end
         S_VRND: begin
            prod_in  = yval;
            state_in = S_VREC;
         end
         S_VREC: begin
            vol_in   = (vq > {1'b0, mfs_pkg::VOL_MAX}) ? mfs_pkg::VOL_MAX
                                                     : vq[mfs_pkg::VOL_W-1:0];
            state_in = S_DONE;
         end
         S_DONE: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         level_ff    <= '0;
         start_ff    <= '0;
         target_ff   <= '0;
         len_ff      <= '0;
         elap_ff     <= '0;
         cur_ff      <= '0;
         cur_v_ff    <= 1'b0;
         pend_ff     <= '0;
         pend_v_ff   <= 1'b0;
         pend_lvl_ff <= '0;
         pend_fin_ff <= '0;
         sw_ff       <= 1'b0;
         started_ff  <= 1'b0;
         vol_ff      <= '0;
      end else begin
         state_ff    <= state_in;
         level_ff    <= level_in;
         start_ff    <= start_in;
         target_ff   <= target_in;
         len_ff      <= len_in;
         elap_ff     <= elap_in;
         cur_ff      <= cur_in;
         cur_v_ff    <= cur_v_in;
         pend_ff     <= pend_in;
         pend_v_ff   <= pend_v_in;
         pend_lvl_ff <= pend_lvl_in;
         pend_fin_ff <= pend_fin_in;
         sw_ff       <= sw_in;
         started_ff  <= started_in;
         vol_ff      <= vol_in;
      end
      cmd_ff  <= cmd_in;
      id_ff   <= id_in;
      tgt_ff  <= tgt_in;
      fout_ff <= fout_in;
      fin_ff  <= fin_in;
      dt_ff   <= dt_in;
      diff_ff <= diff_in;
      prod_ff <= prod_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);

   assign res.volume_level  = vol_ff;
   assign res.playing_track = cur_ff;
   assign res.track_present = cur_v_ff;
   assign res.track_start   = started_ff;
   assign res.fade_busy     = (len_ff != '0);

`ifndef ASSERT_OFF
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_MAX)
      else $error("level above full scale");

   a_ramp_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) && (len_ff != '0) |-> (elap_ff < len_ff))
      else $error("idle with an expired ramp");

   a_switch_pair: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff == sw_ff)
      else $error("pending track and switch flag disagree");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_RDWT))
      else $error("divider finished outside the ramp wait state");
`endif

endmodule
